// ----- sv/sorted_list_table_defines.svh -----
// assertion macros for the sorted list table
// no dependencies; included by modules that carry concurrent checks
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_list_table check failed");

// next-cycle implication, disabled while reset is asserted
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_list_table check failed");

`endif

// ----- sv/slt_pkg.sv -----
// types and constants shared by the sorted list table
// no dependencies
package slt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  localparam logic signed [31:0] EMPTY_HEAD = -32'sd9999;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         comparisons;
    logic [4:0]         entry_count;
    logic signed [31:0] head_value;
  } out_word_t;

endpackage

// ----- sv/slt_ram.sv -----
// single-port-write, single-port-read storage for the table entries
// read data registered; no package use
module slt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/sorted_list_table.sv -----
// sorted list table: ascending store of signed 32-bit values with insert,
// remove, search and clear. uses slt_pkg, slt_ram and the assertion header
//
// in channel (in_valid / in_stall / in_word): one command word, taken at a
// clock edge with in_valid high and in_stall low. out channel (out_valid /
// out_stall / out_word): one result word per command, held while out_stall
// is high. cfg channel (cfg_valid / cfg_ready / cfg_data) writes search_mode;
// cfg_ready is always high, write only while the block is idle.
// the memory does one read and one write a cycle. clear, a full insert and
// commands on an empty table go straight to the result; insert walks back
// from the tail, moving each entry above the new value up one place, remove
// scans up to the value and shifts the rest down, search visits entries from
// the head. commands run one at a time, the next word is taken the cycle
// after the result is loaded.
// reset: rst_n low clears the count, sets search_mode to 1 and empties the
// output register; the memory itself is not cleared.
// stall: a finished result sits in the output register while the next
// command is taken; a following result waits in its final state until the
// output register frees up.
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

`include "sorted_list_table_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_LAST,
    ST_RM_SCAN,
    ST_RM_SHIFT,
    ST_SR_SCAN,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               mode_r, mode_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic signed [31:0] head_r, head_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [4:0]         res_comp_r, res_comp_nxt;

  // memory port controls
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [31:0]        mem_rdata;
  logic signed [31:0] rd_val;

  logic [CW-1:0]      ptr_inc;
  logic               scan_last;

  slt_ram #(
    .DEPTH (DEPTH),
    .WIDTH (32)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign rd_val    = $signed(mem_rdata);
  assign ptr_inc   = CW'(ptr_r) + CW'(1);
  // current entry is the last stored one
  assign scan_last = (ptr_inc == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    mode_nxt       = mode_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    value_nxt      = value_r;
    ptr_nxt        = ptr_r;
    head_nxt       = head_r;
    res_status_nxt = res_status_r;
    res_comp_nxt   = res_comp_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = value_r;
    mem_raddr      = '0;

    if (cfg_valid) begin
      mode_nxt = cfg_data;
    end

    // receiver took the pending word
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          value_nxt      = in_word.value;
          res_status_nxt = STAT_OK;
          res_comp_nxt   = '0;
          ptr_nxt        = '0;
          case (in_word.command)
            CMD_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = ST_DONE;
              end else if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_word.value;
                count_nxt = CW'(1);
                state_nxt = ST_DONE;
              end else begin
                // walk back from the tail, hole at the old count
                mem_raddr = AW'(count_r - CW'(1));
                ptr_nxt   = AW'(count_r);
                state_nxt = ST_INS;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_NOT_FOUND;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_RM_SCAN;
              end
            end
            CMD_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_NOT_FOUND;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_SR_SCAN;
              end
            end
            default: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_INS: begin
        // rd_val holds entry ptr-1
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        if (rd_val > value_r) begin
          mem_wdata = mem_rdata;
          ptr_nxt   = ptr_r - AW'(1);
          mem_raddr = ptr_r - AW'(2);
          if (ptr_r == AW'(1)) begin
            state_nxt = ST_INS_LAST;
          end
        end else begin
          mem_wdata = value_r;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_INS_LAST: begin
        // new value becomes the head
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = value_r;
        count_nxt = count_r + CW'(1);
        state_nxt = ST_DONE;
      end

      ST_RM_SCAN: begin
        // rd_val holds entry ptr, prefetch the next one
        mem_raddr = ptr_r + AW'(1);
        if (rd_val < value_r) begin
          if (scan_last) begin
            res_status_nxt = STAT_NOT_FOUND;
            state_nxt      = ST_DONE;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end else if (rd_val == value_r) begin
          if (scan_last) begin
            count_nxt = count_r - CW'(1);
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RM_SHIFT;
          end
        end else begin
          res_status_nxt = STAT_NOT_FOUND;
          state_nxt      = ST_DONE;
        end
      end

      ST_RM_SHIFT: begin
        // rd_val holds entry ptr+1, move it down one place
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata;
        mem_raddr = ptr_r + AW'(2);
        ptr_nxt   = ptr_r + AW'(1);
        if (CW'(ptr_r) + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_SR_SCAN: begin
        mem_raddr    = ptr_r + AW'(1);
        res_comp_nxt = 5'(ptr_inc);
        if (rd_val == value_r) begin
          res_status_nxt = STAT_OK;
          state_nxt      = ST_DONE;
        end else if ((mode_r && (rd_val > value_r)) || scan_last) begin
          res_status_nxt = STAT_NOT_FOUND;
          state_nxt      = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.status      = res_status_r;
          out_word_nxt.comparisons = res_comp_r;
          out_word_nxt.entry_count = 5'(count_r);
          out_word_nxt.head_value  = (count_r == '0) ? EMPTY_HEAD : head_r;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // shadow copy of entry 0
    if (mem_we && (mem_waddr == '0)) begin
      head_nxt = $signed(mem_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r   <= out_word_nxt;
    value_r      <= value_nxt;
    ptr_r        <= ptr_nxt;
    head_r       <= head_nxt;
    res_status_r <= res_status_nxt;
    res_comp_r   <= res_comp_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  // checks
  `SLT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `SLT_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != ST_IDLE)
  `SLT_ASSERT_NEXT(a_done_loads, clk, rst_n,
                   (state_r == ST_DONE) && (!out_valid_r || !out_stall), out_valid_r)

endmodule

// ----- dv/tb_sorted_list_table.sv -----
// self-checking testbench for sorted_list_table: directed and random command words
// depends on slt_pkg and the sorted_list_table rtl; a small tracker class predicts results
module tb_sorted_list_table
  import slt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 16;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 182;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int TIMEOUT_NS    = 5_000_000;

  // tracks the table contents and the result word each accepted command owes
  class sorted_list_tracker;
    localparam int TABLE_DEPTH = 16;
    logic signed [31:0] entries [TABLE_DEPTH];
    int                 count;
    bit                 early_stop;
    out_word_t          owed_words [$];
    int                 errors;

    function new();
      count      = 0;
      early_stop = 1'b1;
      errors     = 0;
    endfunction

    function void note_command(in_word_t w);
      out_word_t          r;
      logic signed [31:0] v;
      int                 pos;
      int                 i;
      int                 visits;
      bit                 found;
      v        = w.value;
      r.status = STAT_OK;
      visits   = 0;
      found    = 1'b0;
      case (w.command)
        CMD_INSERT: begin
          if (count >= TABLE_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            // equal values go after the ones already stored
            pos = 0;
            while (pos < count && entries[pos] <= v) pos++;
            for (i = count; i > pos; i--) entries[i] = entries[i - 1];
            entries[pos] = v;
            count++;
          end
        end
        CMD_REMOVE: begin
          pos = 0;
          while (pos < count && entries[pos] < v) pos++;
          if (pos >= count || entries[pos] != v) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            for (i = pos; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
          end
        end
        CMD_SEARCH: begin
          for (i = 0; i < count; i++) begin
            visits++;
            if (entries[i] == v) begin
              found = 1'b1;
              break;
            end
            if (early_stop && entries[i] > v) break;
          end
          r.status = found ? STAT_OK : STAT_NOT_FOUND;
        end
        default: count = 0;
      endcase
      r.comparisons = visits[4:0];
      r.entry_count = count[4:0];
      r.head_value  = (count > 0) ? entries[0] : EMPTY_HEAD;
      owed_words.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (owed_words.size() == 0) begin
        $error("result word with nothing owed: status %0d count %0d head %0d",
               got.status, got.entry_count, got.head_value);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.comparisons !== want.comparisons) begin
        $error("comparisons: expected %0d, got %0d", want.comparisons, got.comparisons);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.head_value !== want.head_value) begin
        $error("head_value: expected %0d, got %0d", want.head_value, got.head_value);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  sorted_list_tracker tracker = new();

  // per-phase traffic shaping, set by the main sequence
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, counted down by the receiver process
  int hold_left      = 0;

  sorted_list_table #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // offer one command word, with random idle cycles first; called at a clock edge
  task automatic send_command(input cmd_t cmd, input logic signed [31:0] value);
    in_word_t w;
    in_word_t noise;
    w = '{command: cmd, value: value};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      // idle payload is junk, the block must not take it
      noise = '{command: cmd_t'($urandom_range(0, 3)), value: $urandom};
      in_valid <= 1'b0;
      in_word  <= noise;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    // in_stall is read before the edge updates land, so this is the accept edge
    do @(posedge clk); while (in_stall);
    tracker.note_command(w);
  endtask

  // stop offering and wait until every owed result word is back or DRAIN_LIMIT runs out
  task automatic drain_results();
    int n;
    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && tracker.owed_words.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // search_mode write, only while the block is idle
  task automatic write_search_mode(input bit mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.early_stop = mode;
  endtask

  // values that often collide with stored ones, plus edge values, small values and full-range noise
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && tracker.count > 0)
      return tracker.entries[$urandom_range(0, tracker.count - 1)];
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return EMPTY_HEAD;
      3:       return 32'sd0;
      4:       return -32'sd1;
      5, 6:    return $signed($urandom_range(0, 15)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  // fill-leaning phases push the table toward full, drain-leaning ones toward empty
  function automatic cmd_t pick_command(input bit fill_lean);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return CMD_CLEAR;
    if (roll < (fill_lean ? 58 : 30)) return CMD_INSERT;
    if (roll < (fill_lean ? 78 : 75)) return CMD_REMOVE;
    return CMD_SEARCH;
  endfunction

  // result side: check every accepted word, then decide the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.check_result(out_word);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    int p;
    int k;
    int idle_plan  [4] = '{0, 67, 0, 17};
    int stall_plan [4] = '{0, 0, 67, 17};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, search_mode still at its reset value of early stop
    send_command(CMD_CLEAR, 32'sd0);
    send_command(CMD_SEARCH, 32'sd0);          // search on an empty table
    send_command(CMD_REMOVE, 32'sd5);          // remove on an empty table
    send_command(CMD_INSERT, 32'sh7fff_ffff);
    send_command(CMD_INSERT, 32'sh8000_0000);
    send_command(CMD_INSERT, EMPTY_HEAD);
    send_command(CMD_INSERT, 32'sd0);
    send_command(CMD_INSERT, 32'sd0);          // duplicate lands after the first
    send_command(CMD_INSERT, -32'sd1);
    send_command(CMD_SEARCH, 32'sd0);
    send_command(CMD_SEARCH, 32'sd5);          // absent, stops at first larger
    send_command(CMD_SEARCH, 32'sh7fff_ffff);  // walks to the tail
    send_command(CMD_REMOVE, 32'sd0);
    send_command(CMD_REMOVE, 32'sd5);          // absent value
    // fill up, then one refused insert and a search over a full table
    for (k = 0; k < 11; k++) send_command(CMD_INSERT, $urandom);
    send_command(CMD_INSERT, 32'sd1);
    send_command(CMD_SEARCH, 32'sd100);
    send_command(CMD_CLEAR, $urandom);

    // random part, phases alternate search_mode and traffic shape
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_search_mode(p[0] ? 1'b1 : 1'b0);
      send_idle_pct  = idle_plan[p % 4];
      recv_stall_pct = stall_plan[p % 4];
      // receiver holds off while the sender keeps offering, so the block backs up
      if (p % 4 == 0) hold_left = HOLD_CYCLES;
      for (k = 0; k < PHASE_WORDS; k++)
        send_command(pick_command(p % 3 != 2), pick_value());
    end

    drain_results();
    if (tracker.owed_words.size() != 0) begin
      $error("%0d result words never arrived", tracker.owed_words.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
